// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true out of reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/core/ptiw_pkg.sv =====
// shared types, constants and the arctangent table of the phasor-to-waveform unit
`default_nettype none
package ptiw_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int MAX_OUT      = 8;

  // cordic gain correction 0.6072529 in q0.30
  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  // cordic datapath widths
  localparam int XW = 52;
  localparam int ZW = 34;

  // divider widths
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 11;

  // configuration register indexes
  localparam logic [7:0] REG_PHASE_PER_STEP = 8'd0;
  localparam logic [7:0] REG_SUBSTEPS       = 8'd1;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_req_t;

  typedef struct packed {
    logic [31:0] amp_prev;
    logic [31:0] phase_prev;
    logic [31:0] amp_now;
    logic [31:0] phase_now;
  } phasor_t;

  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/phasor_to_instantaneous_waveform_unit.sv =====
// phasor to instantaneous waveform unit: sequencer around the phasor store
// Usage:
//  in channel: tuser carries the operation (0 load phasor, 1 tick), tdata the
//  channel, real and imaginary parts, gain, step count and substep. One item is
//  taken at a time; in_tready is high only while the sequencer is idle.
//  A load reads the channel's entry, moves now to previous and writes the new
//  amplitude and phase (squares, square root, vectoring cordic, read and
//  write-back). It gives no result.
//  A tick gives one sample per channel, tlast on the last; per channel it runs
//  two cordic rotations on the shared cordic and a blend division.
//  out channel: an output register holds each sample; while out_tready is low
//  the sequencer waits on the next sample and no input is taken.
//  cfg channel: always ready, index 0 phase per step, index 1 substeps.
//  Reset: synchronous, active low; clears all phasors to zero, phase per step
//  to 0 and substeps to 1.
`default_nettype none
`include "assert_macros.svh"
module phasor_to_instantaneous_waveform_unit #(
  parameter int CHANNELS = ptiw_pkg::CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // channel[2:0], real_part[34:3], imag_part[66:35], gain[90:67],
  // step_count[122:91], substep[133:123], zero[135:134]
  input  logic [135:0] in_tdata,
  // operation[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_channel[2:0], sample[34:3], zero[39:35]
  output logic [39:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ptiw_pkg::*;

  localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NOUT = (CHANNELS > MAX_OUT) ? MAX_OUT : CHANNELS;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LD_SQ1   = 5'd1;
  localparam logic [4:0] S_LD_SQ2   = 5'd2;
  localparam logic [4:0] S_LD_SQRT  = 5'd3;
  localparam logic [4:0] S_LD_AMP   = 5'd4;
  localparam logic [4:0] S_LD_ATAN  = 5'd5;
  localparam logic [4:0] S_LD_RD    = 5'd6;
  localparam logic [4:0] S_LD_WR    = 5'd7;
  localparam logic [4:0] S_TK_MUL1  = 5'd8;
  localparam logic [4:0] S_TK_MUL2  = 5'd9;
  localparam logic [4:0] S_TK_DIV   = 5'd10;
  localparam logic [4:0] S_CH_RD    = 5'd11;
  localparam logic [4:0] S_CH_CAP   = 5'd12;
  localparam logic [4:0] S_COS_P    = 5'd13;
  localparam logic [4:0] S_COS_N    = 5'd14;
  localparam logic [4:0] S_MUL_P    = 5'd15;
  localparam logic [4:0] S_MUL_N    = 5'd16;
  localparam logic [4:0] S_BL_START = 5'd17;
  localparam logic [4:0] S_BL_WAIT  = 5'd18;
  localparam logic [4:0] S_OUT      = 5'd19;

  logic [4:0]  state_r, state_nxt;
  logic [31:0] pps_r;
  logic [10:0] substeps_r;

  // latched item
  logic [2:0]         ld_ch_r;
  logic signed [31:0] re_r, im_r;
  logic [23:0]        gain_r;
  logic [31:0]        step_r;
  logic [10:0]        m_r, s_r;

  logic [63:0]  sq_r;
  logic         sat_mag_r;
  logic [31:0]  mag_r, amp_r, phase_r, base_r, wt_r;
  logic [2:0]   ch_r;
  logic signed [35:0] cp_r, cn_r;
  logic signed [47:0] bp_r;
  logic signed [48:0] num_r;
  logic signed [31:0] sample_r;

  logic        out_valid_r, out_last_r;
  logic [2:0]  out_ch_r;
  logic [31:0] out_sample_r;

  logic        in_xfer, in_op, ch_ok, out_free;
  logic [2:0]  in_ch;
  logic signed [63:0] sq_re, sq_im;
  logic [63:0] sum_c;
  logic [56:0] prod_c;
  logic [40:0] ampv;
  logic [31:0] amp_c, base_c;
  logic [42:0] pm_c;
  logic signed [11:0] diff_c;
  logic signed [47:0] bp_c, cnm_c;
  logic signed [48:0] num_c;
  logic [48:0]  abs_c;
  logic signed [50:0] q_s;
  logic [6:0]   ld_ext, ch_ext;

  // shared units
  cordic_req_t creq;
  logic [31:0] c_amp, c_theta, c_angle;
  logic        cord_busy, cord_done;
  logic signed [35:0] c_cos;
  logic        sqrt_start, sqrt_busy, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic        mem_rd, mem_wr;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  phasor_t     mem_wdata, mem_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign in_ch     = in_tdata[2:0];
  assign ch_ok     = 32'(in_ch) < 32'(CHANNELS);
  assign out_free  = !out_valid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pps_r      <= '0;
      substeps_r <= 11'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PHASE_PER_STEP: pps_r      <= cfg_data;
        REG_SUBSTEPS:       substeps_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // arithmetic between registers
  assign sq_re  = re_r * re_r;
  assign sq_im  = im_r * im_r;
  assign sum_c  = sq_r + sq_im;
  assign prod_c = gain_r * mag_r + 57'd32768;
  assign ampv   = prod_c[56:16];
  assign amp_c  = (|ampv[40:32]) ? 32'hFFFFFFFF : ampv[31:0];
  assign base_c = pps_r * step_r;
  assign pm_c   = pps_r * m_r;
  assign diff_c = $signed({1'b0, s_r}) - $signed({1'b0, m_r});
  assign bp_c   = cp_r * diff_c;
  assign cnm_c  = cn_r * $signed({1'b0, m_r});
  assign num_c  = bp_r + cnm_c;
  assign abs_c  = num_r[48] ? 49'(-num_r) : 49'(num_r);
  assign q_s    = num_r[48] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign ld_ext = {4'b0, ld_ch_r};
  assign ch_ext = {4'b0, ch_r};

  // unit hookups
  assign sqrt_start = (state_r == S_LD_SQ2);
  assign div_start  = (state_r == S_TK_MUL2) || (state_r == S_BL_START);
  assign div_num    = (state_r == S_TK_MUL2) ? {7'b0, pm_c}
                                             : {1'b0, abs_c} + {40'b0, s_r[10:1]};
  assign creq.start = (state_r == S_LD_AMP) || (state_r == S_CH_CAP)
                      || ((state_r == S_COS_P) && cord_done);
  assign creq.vec   = (state_r == S_LD_AMP);
  assign c_amp      = (state_r == S_CH_CAP) ? mem_rdata.amp_prev : mem_rdata.amp_now;
  assign c_theta    = wt_r + ((state_r == S_CH_CAP) ? mem_rdata.phase_prev
                                                    : mem_rdata.phase_now);
  assign mem_rd      = (state_r == S_LD_RD) || (state_r == S_CH_RD);
  assign mem_rd_addr = (state_r == S_LD_RD) ? ld_ext[AW-1:0] : ch_ext[AW-1:0];
  assign mem_wr      = (state_r == S_LD_WR);
  assign mem_wr_addr = ld_ext[AW-1:0];
  assign mem_wdata   = '{amp_prev: mem_rdata.amp_now, phase_prev: mem_rdata.phase_now,
                         amp_now: amp_r, phase_now: phase_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_xfer) begin
                    if (in_op) state_nxt = S_TK_MUL1;
                    else if (ch_ok) state_nxt = S_LD_SQ1;
                  end
      S_LD_SQ1:   state_nxt = S_LD_SQ2;
      S_LD_SQ2:   state_nxt = S_LD_SQRT;
      S_LD_SQRT:  if (sqrt_done) state_nxt = S_LD_AMP;
      S_LD_AMP:   state_nxt = S_LD_ATAN;
      S_LD_ATAN:  if (cord_done) state_nxt = S_LD_RD;
      S_LD_RD:    state_nxt = S_LD_WR;
      S_LD_WR:    state_nxt = S_IDLE;
      S_TK_MUL1:  state_nxt = S_TK_MUL2;
      S_TK_MUL2:  state_nxt = S_TK_DIV;
      S_TK_DIV:   if (div_done) state_nxt = S_CH_RD;
      S_CH_RD:    state_nxt = S_CH_CAP;
      S_CH_CAP:   state_nxt = S_COS_P;
      S_COS_P:    if (cord_done) state_nxt = S_COS_N;
      S_COS_N:    if (cord_done) state_nxt = S_MUL_P;
      S_MUL_P:    state_nxt = S_MUL_N;
      S_MUL_N:    state_nxt = S_BL_START;
      S_BL_START: state_nxt = S_BL_WAIT;
      S_BL_WAIT:  if (div_done) state_nxt = S_OUT;
      S_OUT:      if (out_free) begin
                    state_nxt = (ch_r == 3'(NOUT - 1)) ? S_IDLE : S_CH_RD;
                  end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_TK_DIV) begin
        ch_r <= '0;
      end else if ((state_r == S_OUT) && out_free) begin
        ch_r <= ch_r + 3'd1;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ld_ch_r <= in_ch;
      re_r    <= in_tdata[34:3];
      im_r    <= in_tdata[66:35];
      gain_r  <= in_tdata[90:67];
      step_r  <= in_tdata[122:91];
      m_r     <= in_tdata[133:123];
      s_r     <= (substeps_r == 11'd0) ? 11'd1 : substeps_r;
    end
    if (state_r == S_LD_SQ1) sq_r <= sq_re;
    if (state_r == S_LD_SQ2) sat_mag_r <= sum_c[63];
    if ((state_r == S_LD_SQRT) && sqrt_done) mag_r <= sat_mag_r ? 32'hFFFFFFFF : sqrt_root;
    if (state_r == S_LD_AMP) amp_r <= amp_c;
    if ((state_r == S_LD_ATAN) && cord_done) phase_r <= c_angle;
    if (state_r == S_TK_MUL1) base_r <= base_c;
    if ((state_r == S_TK_DIV) && div_done) wt_r <= base_r + div_quo[31:0];
    if ((state_r == S_COS_P) && cord_done) cp_r <= c_cos;
    if ((state_r == S_COS_N) && cord_done) cn_r <= c_cos;
    if (state_r == S_MUL_P) bp_r <= bp_c;
    if (state_r == S_MUL_N) num_r <= num_c;
    if ((state_r == S_BL_WAIT) && div_done) begin
      if (q_s > 51'sd2147483647) sample_r <= 32'sh7FFFFFFF;
      else if (q_s < -51'sd2147483648) sample_r <= 32'sh80000000;
      else sample_r <= q_s[31:0];
    end
    if ((state_r == S_OUT) && out_free) begin
      out_ch_r     <= ch_r;
      out_sample_r <= sample_r;
      out_last_r   <= (ch_r == 3'(NOUT - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_sample_r, out_ch_r};
  assign out_tlast  = out_last_r;

  ptiw_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (creq),
    .vec_x    (re_r),
    .vec_y    (im_r),
    .amp      (c_amp),
    .theta    (c_theta),
    .busy     (cord_busy),
    .done     (cord_done),
    .angle    (c_angle),
    .cos_term (c_cos)
  );

  ptiw_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sum_c[62:0], 1'b0}),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  ptiw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (s_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  ptiw_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  `ASSERT_CLK(a_idle_quiet, (state_r == S_IDLE) |-> !(cord_busy || sqrt_busy || div_busy), "unit busy while idle")
  `ASSERT_CLK(a_last_chan, (out_tvalid && out_tlast) |-> (out_ch_r == 3'(NOUT - 1)), "tlast on wrong channel")
  `ASSERT_CLK(a_out_source, $rose(out_valid_r) |-> ($past(state_r) == S_OUT), "sample from wrong state")

endmodule
`default_nettype wire

// ===== rtl/core/ptiw_cordic.sv =====
// shared iterative cordic: vectoring for the phase, rotation for amplitude times cosine
`default_nettype none
module ptiw_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptiw_pkg::cordic_req_t req,
  input  logic [31:0]           vec_x,
  input  logic [31:0]           vec_y,
  input  logic [31:0]           amp,
  input  logic [31:0]           theta,
  output logic                  busy,
  output logic                  done,
  output logic [31:0]           angle,
  output logic signed [35:0]    cos_term
);
  import ptiw_pkg::*;

  logic signed [XW-1:0] x_r, y_r, xs, ys, vx, vy, x0v, rnd, shr;
  logic signed [ZW-1:0] z_r, tab, z0r;
  logic [4:0]           iter_r;
  logic                 run_r, done_r, vec_r, flip_r, zero_r, ccw, flip, neg;
  logic [61:0]          kprod;
  logic [31:0]          th;
  logic signed [35:0]   c;

  assign vx    = XW'($signed(vec_x));
  assign vy    = XW'($signed(vec_y));
  assign neg   = vec_x[31];
  assign x0v   = neg ? -vx : vx;
  assign kprod = {30'b0, amp} * {32'b0, KINV_Q30};
  // quadrants 1 and 2 fold by half a turn
  assign flip  = theta[31] ^ theta[30];
  assign th    = {theta[31] ^ flip, theta[30:0]};
  assign z0r   = ZW'($signed(th));

  assign xs  = x_r >>> iter_r;
  assign ys  = y_r >>> iter_r;
  assign tab = {2'b0, atan_tab(iter_r)};
  assign ccw = vec_r ? !(y_r > 0) : !z_r[ZW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        iter_r <= '0;
      end else if (run_r) begin
        iter_r <= iter_r + 5'd1;
        if (iter_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      vec_r <= req.vec;
      if (req.vec) begin
        x_r    <= x0v;
        y_r    <= neg ? -vy : vy;
        z_r    <= neg ? ZW'(34'h080000000) : '0;
        zero_r <= (vec_x == 32'd0) && (vec_y == 32'd0);
        flip_r <= 1'b0;
      end else begin
        x_r    <= {4'b0, kprod[61:14]};
        y_r    <= '0;
        z_r    <= z0r;
        zero_r <= 1'b0;
        flip_r <= flip;
      end
    end else if (run_r) begin
      if (ccw) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - tab;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + tab;
      end
    end
  end

  assign rnd      = x_r + XW'(32768);
  assign shr      = rnd >>> 16;
  assign c        = shr[35:0];
  assign cos_term = flip_r ? -c : c;
  assign angle    = zero_r ? 32'd0 : z_r[31:0];
  assign busy     = run_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptiw_isqrt.sv =====
// bit-serial integer square root of a 64-bit value, two radicand bits per cycle
`default_nettype none
module ptiw_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] v_r;
  logic [34:0] rem_r, rem_sh, trial;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        run_r, done_r, fits;

  assign rem_sh = {rem_r[32:0], v_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      v_r    <= {v_r[61:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], fits};
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptiw_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module ptiw_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ptiw_pkg::DIV_NW-1:0] num,
  input  logic [ptiw_pkg::DIV_DW-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic [ptiw_pkg::DIV_NW-1:0] quo
);
  import ptiw_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] n_r;
  logic [DIV_DW-1:0] d_r, rem_r;
  logic [DIV_DW:0]   rs;
  logic [CW-1:0]     cnt_r;
  logic              run_r, done_r, ge;

  assign rs = {rem_r, n_r[DIV_NW-1]};
  assign ge = rs >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? DIV_DW'(rs - {1'b0, d_r}) : rs[DIV_DW-1:0];
      n_r   <= {n_r[DIV_NW-2:0], ge};
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quo  = n_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptiw_mem.sv =====
// per-channel phasor store, one read and one write port, registered read
`default_nettype none
`include "assert_macros.svh"
module ptiw_mem #(
  parameter int CHANNELS = ptiw_pkg::CHANNELS_DEF,
  parameter int AW       = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ptiw_pkg::phasor_t wr_data,
  output ptiw_pkg::phasor_t rd_data
);
  import ptiw_pkg::*;

  phasor_t             phasor_mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  phasor_t             rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      phasor_mem[wr_addr] <= wr_data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? phasor_mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

  `ASSERT_NEVER(a_rw_same_cycle, rd_en && wr_en, "read and write in one cycle")
  `ASSERT_CLK(a_rd_range, rd_en |-> (32'(rd_addr) < 32'(CHANNELS)), "read beyond channels")
  `ASSERT_CLK(a_wr_range, wr_en |-> (32'(wr_addr) < 32'(CHANNELS)), "write beyond channels")

endmodule
`default_nettype wire
